FILE: rtl/core/mstt_pkg.sv
// ============================================================================
// mstt_pkg
// Shared types and codes for the multi-slot tick timer bank.
// ============================================================================
package mstt_pkg;

    localparam int TICK_W   = 32;
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 8;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED    = 2'd3;

    // Item result as it is built up along the chain.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   given;
        logic [MASK_W-1:0]   mask;
    } res_t;

    // Item command plus its partial result, handed from cell to cell.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [TICK_W-1:0]   period;
        logic                reload;
        logic [TICK_W-1:0]   now;
        res_t                res;
    } pkt_t;

endpackage

FILE: rtl/core/mstt_cell.sv
// ============================================================================
// mstt_cell
// One timer slot: holds the slot state, acts on the item passing through and
// hands the item with its updated result to the next cell.
// ============================================================================
module mstt_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  mstt_pkg::pkt_t    in_pkt,
    output logic              out_vld,
    output mstt_pkg::pkt_t    out_pkt
);

    localparam logic                         ADDRESSABLE = (IDX < 8);
    localparam logic [mstt_pkg::SLOT_W-1:0]  MY_SLOT     = mstt_pkg::SLOT_W'(IDX);
    localparam logic [mstt_pkg::MASK_W-1:0]  MASK_BIT    =
        (IDX < mstt_pkg::MASK_W) ? mstt_pkg::MASK_W'(1 << IDX) : '0;

    logic                        used_reg, used_next;
    logic                        active_reg, active_next;
    logic                        reload_reg, reload_next;
    logic [mstt_pkg::TICK_W-1:0] period_reg, period_next;
    logic [mstt_pkg::TICK_W-1:0] expiry_reg, expiry_next;
    logic                        vld_reg;
    mstt_pkg::pkt_t              pkt_reg, pkt_next;

    logic [mstt_pkg::TICK_W-1:0] diff;
    logic                        reached;
    logic                        addressed;

    // Wrap-safe compare: the slot is due once now - expiry is not negative.
    assign diff      = in_pkt.now - expiry_reg;
    assign reached   = ~diff[mstt_pkg::TICK_W-1];
    assign addressed = ADDRESSABLE && (in_pkt.slot == MY_SLOT) && used_reg;

    always_comb
    begin
        used_next   = used_reg;
        active_next = active_reg;
        reload_next = reload_reg;
        period_next = period_reg;
        expiry_next = expiry_reg;
        pkt_next    = in_pkt;
        if (in_vld)
        begin
            case (in_pkt.action)
                mstt_pkg::ACT_CREATE:
                begin
                    // Status still reads full only until some cell claims.
                    if ((in_pkt.res.status == mstt_pkg::ST_FULL) && !used_reg)
                    begin
                        used_next          = 1'b1;
                        active_next        = 1'b0;
                        reload_next        = in_pkt.reload;
                        period_next        = in_pkt.period;
                        expiry_next        = '0;
                        pkt_next.res.status = mstt_pkg::ST_OK;
                        pkt_next.res.given  = MY_SLOT;
                    end
                end
                mstt_pkg::ACT_START, mstt_pkg::ACT_STOP, mstt_pkg::ACT_DELETE:
                begin
                    if (addressed)
                    begin
                        pkt_next.res.status = mstt_pkg::ST_OK;
                        case (in_pkt.action)
                            mstt_pkg::ACT_START:
                            begin
                                expiry_next = in_pkt.now + period_reg;
                                active_next = 1'b1;
                            end
                            mstt_pkg::ACT_STOP:
                            begin
                                active_next = 1'b0;
                            end
                            default:
                            begin
                                used_next   = 1'b0;
                                active_next = 1'b0;
                            end
                        endcase
                    end
                end
                mstt_pkg::ACT_TICK:
                begin
                    if (used_reg && active_reg && reached)
                    begin
                        if (reload_reg)
                        begin
                            expiry_next = expiry_reg + period_reg;
                        end
                        else
                        begin
                            active_next = 1'b0;
                        end
                        pkt_next.res.mask = in_pkt.res.mask | MASK_BIT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            active_reg <= 1'b0;
            reload_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            active_reg <= active_next;
            reload_reg <= reload_next;
            vld_reg    <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        expiry_reg <= expiry_next;
        pkt_reg    <= pkt_next;
    end

    assign out_vld = vld_reg;
    assign out_pkt = pkt_reg;

endmodule

FILE: rtl/core/multi_slot_tick_timer.sv
// ============================================================================
// multi_slot_tick_timer
// Bank of create/start/stop/delete timer slots checked on each tick item.
// ============================================================================
// Usage:
// The input channel (in_valid/in_stall) takes one command item: create,
// start, stop, delete or tick, with its slot, period, reload flag and the
// current tick. The output channel (out_valid/out_stall) returns exactly one
// result item per command: status, the slot given by a create, and the mask
// of slots that fired on a tick.
// The slots form a row of cells. An item enters the row and moves one cell
// per cycle, each cell acting on its own slot; its result is registered on
// the output side once the item leaves the last cell. A new item is taken
// only after the previous one has left the row, so one item is in the row
// at a time.
// A finished result waits in the output register while the next item is
// taken; if the receiver keeps stalling, a second result is parked in a
// holding register and in_stall stays high until the output drains.
// Reset frees every slot and empties the row and the output side.
// ============================================================================
module multi_slot_tick_timer #(
    parameter int SLOTS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mstt_pkg::ACTION_W-1:0]  action,
    input  logic [mstt_pkg::SLOT_W-1:0]    slot,
    input  logic [mstt_pkg::TICK_W-1:0]    period,
    input  logic                           auto_reload,
    input  logic [mstt_pkg::TICK_W-1:0]    now_tick,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mstt_pkg::STATUS_W-1:0]  status,
    output logic [mstt_pkg::SLOT_W-1:0]    given_slot,
    output logic [mstt_pkg::MASK_W-1:0]    fired_mask
);

    logic                 in_take;
    logic                 out_take;
    logic                 busy_reg, busy_next;
    logic                 ent_vld_reg;
    mstt_pkg::pkt_t       ent_pkt_reg, ent_pkt_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 pend_vld_reg, pend_vld_next;
    mstt_pkg::res_t       out_res_reg, out_res_next;
    mstt_pkg::res_t       pend_res_reg, pend_res_next;

    logic [SLOTS:0]       link_vld;
    mstt_pkg::pkt_t       link_pkt [SLOTS+1];

    assign in_stall = busy_reg || pend_vld_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_vld_reg && !out_stall;

    // The starting status is what the item reports if no cell changes it.
    always_comb
    begin
        ent_pkt_next.action     = action;
        ent_pkt_next.slot       = slot;
        ent_pkt_next.period     = period;
        ent_pkt_next.reload     = auto_reload;
        ent_pkt_next.now        = now_tick;
        ent_pkt_next.res.given  = '0;
        ent_pkt_next.res.mask   = '0;
        case (action)
            mstt_pkg::ACT_CREATE:
            begin
                ent_pkt_next.res.status = (period == '0) ? mstt_pkg::ST_ZERO_PERIOD
                                                         : mstt_pkg::ST_FULL;
            end
            mstt_pkg::ACT_START, mstt_pkg::ACT_STOP, mstt_pkg::ACT_DELETE:
            begin
                ent_pkt_next.res.status = mstt_pkg::ST_NOT_USED;
            end
            default:
            begin
                ent_pkt_next.res.status = mstt_pkg::ST_OK;
            end
        endcase
    end

    assign link_vld[0] = ent_vld_reg;
    assign link_pkt[0] = ent_pkt_reg;

    for (genvar gi = 0; gi < SLOTS; gi++)
    begin : g_cell
        mstt_cell #(
            .IDX (gi)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (link_vld[gi]),
            .in_pkt  (link_pkt[gi]),
            .out_vld (link_vld[gi+1]),
            .out_pkt (link_pkt[gi+1])
        );
    end

    always_comb
    begin
        busy_next     = busy_reg;
        out_vld_next  = out_vld_reg;
        pend_vld_next = pend_vld_reg;
        out_res_next  = out_res_reg;
        pend_res_next = pend_res_reg;
        if (in_take)
        begin
            busy_next = 1'b1;
        end
        if (link_vld[SLOTS])
        begin
            busy_next = 1'b0;
            if (!out_vld_reg || out_take)
            begin
                out_vld_next = 1'b1;
                out_res_next = link_pkt[SLOTS].res;
            end
            else
            begin
                pend_vld_next = 1'b1;
                pend_res_next = link_pkt[SLOTS].res;
            end
        end
        else if (out_take)
        begin
            out_vld_next  = pend_vld_reg;
            out_res_next  = pend_res_reg;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            ent_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            ent_vld_reg  <= in_take;
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_pkt_reg  <= ent_pkt_next;
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid  = out_vld_reg;
    assign status     = out_res_reg.status;
    assign given_slot = out_res_reg.given;
    assign fired_mask = out_res_reg.mask;

    // Only one item may walk the row of cells at a time.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(link_vld) <= 1)
        else $error("more than one item in the cell row");

    // Any item in the row must have been counted as in flight.
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (link_vld != '0) |-> busy_reg)
        else $error("item in the row while the bank is not busy");

    // A parked result always has a result ahead of it.
    a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> out_vld_reg)
        else $error("holding register full with the output empty");

    // An accepted item is at the input of the first cell on the next edge.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (ent_vld_reg && busy_reg))
        else $error("accepted item did not enter the row");

endmodule
